/* design/sobm_pkg.sv */
// Shared types, constants and helpers for the Sobel edge magnitude block.
`default_nettype none

package sobm_pkg;

    // Frame geometry defaults and window size
    localparam int IMAGE_WIDTH_DEF  = 180;
    localparam int IMAGE_HEIGHT_DEF = 120;
    localparam int KERNEL_SIZE      = 3;
    localparam int TAP_COUNT        = KERNEL_SIZE * KERNEL_SIZE;

    // Pixel and mask widths
    localparam int PIX_W   = 16;
    localparam int GRAY_W  = 5;
    localparam int COEF_W  = 7;
    localparam int MASK_W  = COEF_W * TAP_COUNT;
    localparam int PROD_W  = GRAY_W + COEF_W;
    localparam int GRAD_W  = 16;
    localparam int TAP_W   = 4;
    localparam int OROW_W  = 7;
    localparam int OCOL_W  = 8;

    // Magnitude path: sum of squares, scaled root, result
    localparam int SQ_W       = 30;
    localparam int ROOT_W     = 26;
    localparam int MAG_W      = 13;
    localparam int ROOT_STEPS = 13;
    localparam int STEP_W     = 4;
    localparam logic [ROOT_W-1:0] ROOT_BIT0 = ROOT_W'(1) << (2 * (ROOT_STEPS - 1));
    localparam int SHIFT_MID  = 6;
    localparam int SHIFT_HIGH = 11;

    // Configuration port
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 64;
    localparam int REG_IDX_BIT = 3;
    localparam logic REG_MASK_X = 1'b0;
    localparam logic REG_MASK_Y = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel_out;
        logic [OROW_W-1:0] out_row;
        logic [OCOL_W-1:0] out_col;
        logic              frame_done;
    } t_pix_out;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SHIFT,
        SEQ_MAC,
        SEQ_START,
        SEQ_WAIT,
        SEQ_OUT
    } t_seq_state;

    typedef enum logic [1:0] {
        MAG_IDLE,
        MAG_SQY,
        MAG_SUM,
        MAG_ROOT
    } t_mag_state;

    // Pick coefficient k out of a packed mask
    function automatic logic signed [COEF_W-1:0] coef_at(
        input logic [MASK_W-1:0] mask_bits,
        input logic [TAP_W-1:0]  k
    );
        logic [MASK_W-1:0] sh;
        sh = mask_bits >> (COEF_W * int'(k));
        return sh[COEF_W-1:0];
    endfunction

    // Replicate the magnitude at bits 0, 6 and 11, truncated
    function automatic logic [PIX_W-1:0] pack_mag(input logic [MAG_W-1:0] m);
        logic [PIX_W-1:0] w;
        w = PIX_W'(m);
        return w | (w << SHIFT_MID) | (w << SHIFT_HIGH);
    endfunction

endpackage

`default_nettype wire

/* design/sobm_mag.sv */
// Magnitude unit: shared squarer, then bit-per-cycle root of (gx^2+gy^2)/10.
`default_nettype none

module sobm_mag (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [sobm_pkg::GRAD_W-1:0]    i_gx,
    input  wire logic signed [sobm_pkg::GRAD_W-1:0]    i_gy,
    output logic                                       o_done,
    output logic [sobm_pkg::MAG_W-1:0]                 o_mag
);
    import sobm_pkg::*;

    t_mag_state r_state, n_state;

    logic [SQ_W-1:0]     r_prod;
    logic [SQ_W-1:0]     r_rem;
    logic [ROOT_W-1:0]   r_res;
    logic [ROOT_W-1:0]   r_bit;
    logic [STEP_W-1:0]   r_step;
    logic                r_done;

    logic signed [GRAD_W-1:0]   sq_in;
    logic signed [2*GRAD_W-1:0] sq_full;
    logic [ROOT_W-1:0]          trial;
    logic [SQ_W-1:0]            trial10;
    logic                       fits;
    logic                       last_step;

    // One squarer serves both gradients
    assign sq_in   = (r_state == MAG_IDLE) ? i_gx : i_gy;
    assign sq_full = sq_in * sq_in;

    // Compare against 10*(res+bit): the root of sum/10 without a divider
    assign trial     = r_res | r_bit;
    assign trial10   = SQ_W'({trial, 3'b000}) + SQ_W'({trial, 1'b0});
    assign fits      = (r_rem >= trial10);
    assign last_step = (r_step == STEP_W'(ROOT_STEPS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            MAG_IDLE: begin
                if (i_start) begin
                    n_state = MAG_SQY;
                end
            end
            MAG_SQY:  n_state = MAG_SUM;
            MAG_SUM:  n_state = MAG_ROOT;
            MAG_ROOT: begin
                if (last_step) begin
                    n_state = MAG_IDLE;
                end
            end
            default:  n_state = MAG_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MAG_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == MAG_ROOT) && last_step;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            MAG_IDLE: begin
                r_prod <= sq_full[SQ_W-1:0];
            end
            MAG_SQY: begin
                r_rem  <= r_prod;
                r_prod <= sq_full[SQ_W-1:0];
            end
            MAG_SUM: begin
                r_rem  <= r_rem + r_prod;
                r_res  <= '0;
                r_bit  <= ROOT_BIT0;
                r_step <= '0;
            end
            MAG_ROOT: begin
                if (fits) begin
                    r_rem <= r_rem - trial10;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_step <= r_step + STEP_W'(1);
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_mag  = r_res[MAG_W-1:0];

endmodule

`default_nettype wire

/* design/sobel_edge_magnitude.sv */
// Top level: line store, 3x3 window, mask MAC sequencer and output register.
`default_nettype none

// Streaming 3x3 edge magnitude over RGB565 frames in raster order, IMAGE_WIDTH
// pixels per row and IMAGE_HEIGHT rows per frame; the gray value is the blue
// field, bits 4:0. Two programmable signed 3x3 masks (written over the APB
// port at byte addresses 0 and 8) give gx and gy, and the result is
// m = floor(sqrt((gx*gx + gy*gy) / 10)) replicated at bits 0, 6 and 11, with
// the row and column of the center pixel, one pixel up and to the left of the
// incoming one. Pixels whose arrival lands in the first two rows or columns
// give no result; such a pixel passes only the accept and the window shift. A
// pixel that gives one, while the output register is free, passes the accept,
// the window shift, the tap-by-tap multiply-accumulate of both masks, the
// shared squarer and adder, the one-bit-per-cycle root unit, the hand-over of
// the root and the load of the output register. Input stall stays high from
// the cycle after the accept until that load, and longer while a held result
// blocks the output register. A finished result waits in the output register
// while the next pixel is taken.
module sobel_edge_magnitude #(
    parameter int IMAGE_WIDTH  = sobm_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = sobm_pkg::IMAGE_HEIGHT_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // pixel input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire sobm_pkg::t_pix_in                   i_in_data,
    // result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output sobm_pkg::t_pix_out                       o_out_data,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [sobm_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [sobm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sobm_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready
);
    import sobm_pkg::*;

    localparam int COL_W = $clog2(IMAGE_WIDTH);
    localparam int ROW_W = $clog2(IMAGE_HEIGHT);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(IMAGE_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(IMAGE_HEIGHT - 1);
    localparam logic [COL_W-1:0] COL_FIRST = COL_W'(KERNEL_SIZE - 1);
    localparam logic [ROW_W-1:0] ROW_FIRST = ROW_W'(KERNEL_SIZE - 1);
    localparam logic [TAP_W-1:0] TAP_LAST  = TAP_W'(TAP_COUNT - 1);
    localparam int LS_W = 2 * GRAY_W;

    t_seq_state r_state, n_state;

    logic [MASK_W-1:0] r_mask_x;
    logic [MASK_W-1:0] r_mask_y;

    // each entry: older row in the upper half, previous row in the lower half
    logic [LS_W-1:0]   line_mem [IMAGE_WIDTH];
    logic [LS_W-1:0]   r_ls_rd;

    logic [GRAY_W-1:0] r_win [TAP_COUNT];
    logic [GRAY_W-1:0] r_gray;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [TAP_W-1:0]  r_tap;

    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;

    logic [OROW_W-1:0] r_res_row;
    logic [OCOL_W-1:0] r_res_col;
    logic              r_res_done;

    logic              r_out_valid;
    t_pix_out          r_out;

    logic              in_accept;
    logic              cfg_write;
    logic              emit;
    logic [COL_W-1:0]  rd_addr;
    logic              mag_start;
    logic              mag_done;
    logic [MAG_W-1:0]  mag;
    logic              out_free;
    logic              out_load;

    logic [GRAY_W-1:0]        tap_pix;
    logic signed [COEF_W-1:0] cx;
    logic signed [COEF_W-1:0] cy;
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;

    assign in_accept = i_in_valid && !o_in_stall;
    assign rd_addr   = i_in_data.frame_start ? '0 : r_col;
    assign emit      = (r_row >= ROW_FIRST) && (r_col >= COL_FIRST);
    assign out_free  = !r_out_valid || !i_out_stall;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_x <= '0;
            r_mask_y <= '0;
        end else if (cfg_write) begin
            case (paddr[REG_IDX_BIT])
                REG_MASK_X: r_mask_x <= pwdata[MASK_W-1:0];
                REG_MASK_Y: r_mask_y <= pwdata[MASK_W-1:0];
                default:    r_mask_x <= r_mask_x;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_IDX_BIT])
            REG_MASK_X: prdata = APB_DATA_W'(r_mask_x);
            REG_MASK_Y: prdata = APB_DATA_W'(r_mask_y);
            default:    prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state   = r_state;
        mag_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            SEQ_IDLE: begin
                if (in_accept) begin
                    n_state = SEQ_SHIFT;
                end
            end
            SEQ_SHIFT: begin
                n_state = emit ? SEQ_MAC : SEQ_IDLE;
            end
            SEQ_MAC: begin
                if (r_tap == TAP_LAST) begin
                    n_state = SEQ_START;
                end
            end
            SEQ_START: begin
                mag_start = 1'b1;
                n_state   = SEQ_WAIT;
            end
            SEQ_WAIT: begin
                if (mag_done) begin
                    n_state = SEQ_OUT;
                end
            end
            SEQ_OUT: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != SEQ_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- line store ----------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ls_rd <= line_mem[rd_addr];
        end
        if (r_state == SEQ_SHIFT) begin
            line_mem[r_col] <= {r_ls_rd[GRAY_W-1:0], r_gray};
        end
    end

    // ---------------- position counters and window ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            for (int t = 0; t < TAP_COUNT; t++) begin
                r_win[t] <= '0;
            end
        end else begin
            if (in_accept && i_in_data.frame_start) begin
                r_col <= '0;
                r_row <= '0;
            end else if (r_state == SEQ_SHIFT) begin
                if (r_col == COL_LAST) begin
                    r_col <= '0;
                    r_row <= (r_row == ROW_LAST) ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            if (r_state == SEQ_SHIFT) begin
                // advance the window one column; top row is the oldest
                for (int i = 0; i < KERNEL_SIZE; i++) begin
                    for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
                        r_win[i*KERNEL_SIZE + j] <= r_win[i*KERNEL_SIZE + j + 1];
                    end
                end
                r_win[KERNEL_SIZE - 1]       <= r_ls_rd[LS_W-1:GRAY_W];
                r_win[2*KERNEL_SIZE - 1]     <= r_ls_rd[GRAY_W-1:0];
                r_win[KERNEL_SIZE*KERNEL_SIZE - 1] <= r_gray;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_gray <= i_in_data.pixel_in[GRAY_W-1:0];
        end
        if (r_state == SEQ_SHIFT) begin
            r_res_row  <= OROW_W'(r_row - ROW_W'(1));
            r_res_col  <= OCOL_W'(r_col - COL_W'(1));
            r_res_done <= (r_row == ROW_LAST) && (r_col == COL_LAST);
        end
    end

    // ---------------- tap-serial multiply-accumulate ----------------
    assign tap_pix = r_win[r_tap];
    assign cx      = coef_at(r_mask_x, r_tap);
    assign cy      = coef_at(r_mask_y, r_tap);
    assign px      = $signed({1'b0, tap_pix}) * cx;
    assign py      = $signed({1'b0, tap_pix}) * cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else if (r_state == SEQ_MAC) begin
            r_tap <= (r_tap == TAP_LAST) ? '0 : r_tap + TAP_W'(1);
        end else begin
            r_tap <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SEQ_SHIFT) begin
            r_gx <= '0;
            r_gy <= '0;
        end else if (r_state == SEQ_MAC) begin
            r_gx <= r_gx + {{(GRAD_W-PROD_W){px[PROD_W-1]}}, px};
            r_gy <= r_gy + {{(GRAD_W-PROD_W){py[PROD_W-1]}}, py};
        end
    end

    sobm_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mag_start),
        .i_gx    (r_gx),
        .i_gy    (r_gy),
        .o_done  (mag_done),
        .o_mag   (mag)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.pixel_out  <= pack_mag(mag);
            r_out.out_row    <= r_res_row;
            r_out.out_col    <= r_res_col;
            r_out.frame_done <= r_res_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* tb/sv/sobel_edge_magnitude_test.sv */
// Self-checking testbench for the Sobel edge magnitude block: directed rows, random frames.
`timescale 1ns / 100ps

module sobel_edge_magnitude_test;
    import sobm_pkg::*;

    localparam int FRAME_COLS    = IMAGE_WIDTH_DEF;
    localparam int FRAME_ROWS    = IMAGE_HEIGHT_DEF;
    localparam int MAG_DIVISOR   = 10;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 600;
    localparam int DIR_ROWS      = 15;

    localparam int FLAT_MAX [TAP_COUNT] = '{default: 63};
    localparam int FLAT_MIN [TAP_COUNT] = '{default: -64};
    localparam int SOBEL_X  [TAP_COUNT] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    localparam int SOBEL_Y  [TAP_COUNT] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

    localparam t_pix_out NO_RESULT = '0;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             start;
        logic [15:0]      reps;
        logic             typed;
        t_pix_out         want;
    } t_dir_row;

    // Directed rows run with both masks at the coefficient extremes.
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{16'hFFFF, 1'b1, 16'd1,   1'b0, NO_RESULT},
        '{16'h001F, 1'b0, 16'd359, 1'b0, NO_RESULT},
        '{16'hFFFF, 1'b0, 16'd2,   1'b0, NO_RESULT},
        // flat gray 31 window: largest magnitude, truncated on packing
        '{16'h001F, 1'b0, 16'd1,   1'b1, '{16'hBEF3, 7'd1, 8'd1, 1'b0}},
        '{16'hFFE0, 1'b0, 16'd1,   1'b0, NO_RESULT},
        '{16'h0000, 1'b0, 16'd1,   1'b0, NO_RESULT},
        // restart mid-frame; old line contents must be overwritten before use
        '{16'h0000, 1'b1, 16'd1,   1'b0, NO_RESULT},
        '{16'h0000, 1'b0, 16'd361, 1'b0, NO_RESULT},
        '{16'hFFE0, 1'b0, 16'd1,   1'b1, '{16'h0000, 7'd1, 8'd1, 1'b0}},
        '{16'h0000, 1'b0, 16'd176, 1'b0, NO_RESULT},
        '{16'h0000, 1'b0, 16'd1,   1'b1, '{16'h0000, 7'd1, 8'd178, 1'b0}},
        '{16'hFFFF, 1'b0, 16'd2,   1'b0, NO_RESULT},
        '{16'h001F, 1'b0, 16'd1,   1'b0, NO_RESULT},
        '{16'hFFE0, 1'b0, 16'd1,   1'b0, NO_RESULT},
        '{16'h5555, 1'b1, 16'd1,   1'b0, NO_RESULT}
    };

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_pix_in               in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b1;
    t_pix_out              out_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    t_pix_out pending_mags [$];
    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int mask_loads   = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_after   = 32'h7FFF_FFFF;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    // Magnitude predictor state
    logic [MASK_W-1:0] em_mask_x = '0;
    logic [MASK_W-1:0] em_mask_y = '0;
    logic [GRAY_W-1:0] em_above  [FRAME_COLS] = '{default: '0};
    logic [GRAY_W-1:0] em_above2 [FRAME_COLS] = '{default: '0};
    logic [GRAY_W-1:0] em_win    [KERNEL_SIZE][KERNEL_SIZE] = '{default: '{default: '0}};
    int em_row = 0;
    int em_col = 0;

    sobel_edge_magnitude i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int tap_coef(input logic [MASK_W-1:0] mask, input int k);
        return int'($signed(mask[k*COEF_W +: COEF_W]));
    endfunction

    function automatic int floor_root(input int unsigned v);
        longint unsigned acc;
        longint unsigned trial;
        acc = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = acc | (64'd1 << b);
            if (trial * trial <= v) acc = trial;
        end
        return int'(acc);
    endfunction

    function automatic logic [APB_DATA_W-1:0] taps_to_mask(input int taps [TAP_COUNT]);
        logic [APB_DATA_W-1:0] m;
        m = '0;
        for (int k = 0; k < TAP_COUNT; k++) m[k*COEF_W +: COEF_W] = COEF_W'(taps[k]);
        return m;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return PIX_W'($urandom) & 16'hFFE0;
            3: return PIX_W'($urandom) | 16'h001F;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic predict_magnitude(input t_pix_in px, output bit emit, output t_pix_out res);
        logic [GRAY_W-1:0] gray;
        logic [PIX_W-1:0]  m16;
        int gx, gy, r, c;
        int unsigned sq;
        gray = px.pixel_in[GRAY_W-1:0];
        if (px.frame_start) begin
            em_row = 0;
            em_col = 0;
        end
        r = em_row;
        c = em_col;
        // shift the window left, newest column enters on the right
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            for (int j = 0; j < KERNEL_SIZE - 1; j++) em_win[i][j] = em_win[i][j+1];
        end
        em_win[0][KERNEL_SIZE-1] = em_above2[c];
        em_win[1][KERNEL_SIZE-1] = em_above[c];
        em_win[2][KERNEL_SIZE-1] = gray;
        em_above2[c] = em_above[c];
        em_above[c]  = gray;
        emit = (r >= 2 && c >= 2);
        res = '0;
        if (emit) begin
            gx = 0;
            gy = 0;
            for (int i = 0; i < KERNEL_SIZE; i++) begin
                for (int j = 0; j < KERNEL_SIZE; j++) begin
                    gx += int'(em_win[i][j]) * tap_coef(em_mask_x, i * KERNEL_SIZE + j);
                    gy += int'(em_win[i][j]) * tap_coef(em_mask_y, i * KERNEL_SIZE + j);
                end
            end
            sq = gx * gx + gy * gy;
            m16 = PIX_W'(floor_root(sq / MAG_DIVISOR));
            res.pixel_out  = m16 | (m16 << SHIFT_MID) | (m16 << SHIFT_HIGH);
            res.out_row    = OROW_W'(r - 1);
            res.out_col    = OCOL_W'(c - 1);
            res.frame_done = (r == FRAME_ROWS - 1 && c == FRAME_COLS - 1);
        end
        c++;
        if (c >= FRAME_COLS) begin
            c = 0;
            r++;
            if (r >= FRAME_ROWS) r = 0;
        end
        em_row = r;
        em_col = c;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic start,
                              input logic typed, input t_pix_out want);
        t_pix_in  req;
        t_pix_out res;
        bit       emit;
        req.pixel_in    = pix;
        req.frame_start = start;
        if ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        predict_magnitude(req, emit, res);
        if (emit) pending_mags.push_back(typed ? want : res);
        items_sent++;
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_mags.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        // a last request without a result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_ADDR_W'(idx) << REG_IDX_BIT;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic expect_reg(input logic idx, input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= APB_ADDR_W'(idx) << REG_IDX_BIT;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== want) begin
            errors++;
            $display("%0t: mask register %0d readback expected %h, got %h",
                     $time, idx, want, got);
        end
    endtask

    task automatic load_masks(input logic [APB_DATA_W-1:0] mx, input logic [APB_DATA_W-1:0] my);
        apb_write(REG_MASK_X, mx);
        apb_write(REG_MASK_Y, my);
        em_mask_x = mx[MASK_W-1:0];
        em_mask_y = my[MASK_W-1:0];
        expect_reg(REG_MASK_X, APB_DATA_W'(em_mask_x));
        expect_reg(REG_MASK_Y, APB_DATA_W'(em_mask_y));
        mask_loads++;
    endtask

    task automatic random_traffic(input int target);
        int   first;
        int   len;
        int   kind;
        logic start;
        first = items_sent;
        while (items_sent - first < target) begin
            // mostly whole frame openings deep enough to give results,
            // then cut-short frames, plain continuation and restart noise
            kind = $urandom_range(9);
            if (kind < 7) len = $urandom_range(600, 380);
            else if (kind == 7) len = $urandom_range(359, 1);
            else len = $urandom_range(200, 1);
            for (int i = 0; i < len; i++) begin
                if (kind <= 7) start = (i == 0);
                else if (kind == 9) start = ($urandom_range(7) == 0);
                else start = 1'b0;
                send_pixel(rand_pixel(), start, 1'b0, NO_RESULT);
            end
        end
    endtask

    // Result checker; fields print as pixel/row/column/frame done
    always @(posedge clk) begin
        t_pix_out want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_mags.size() == 0) begin
                errors++;
                $display("%0t: edge result expected none, got %h/%0d/%0d/%b",
                         $time, out_data.pixel_out, out_data.out_row,
                         out_data.out_col, out_data.frame_done);
            end else begin
                want = pending_mags.pop_front();
                if (out_data !== want) begin
                    errors++;
                    $display("%0t: edge result expected %h/%0d/%0d/%b, got %h/%0d/%0d/%b",
                             $time, want.pixel_out, want.out_row, want.out_col,
                             want.frame_done, out_data.pixel_out, out_data.out_row,
                             out_data.out_col, out_data.frame_done);
                end
            end
        end
    end

    // Result receiver: random stall, plus one long hold to back the block up
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= hold_after) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        expect_reg(REG_MASK_X, '0);
        expect_reg(REG_MASK_Y, '0);

        snd_idle_pct = 32;
        rcv_idle_pct = 87;
        // bit 63 set on the write must be dropped
        load_masks(taps_to_mask(FLAT_MAX) | {1'b1, 63'd0}, taps_to_mask(FLAT_MIN));
        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int n = 0; n < int'(DIR_TAB[r].reps); n++)
                send_pixel(DIR_TAB[r].pixel, DIR_TAB[r].start, DIR_TAB[r].typed,
                           DIR_TAB[r].want);
        end
        settle();

        load_masks(taps_to_mask(SOBEL_X), taps_to_mask(SOBEL_Y));
        hold_after = results_seen + 10;
        random_traffic(300);
        settle();

        snd_idle_pct = 87;
        rcv_idle_pct = 32;
        load_masks({$urandom, $urandom}, {$urandom, $urandom});
        random_traffic(300);
        settle();

        // open a fresh frame and stream it back to back past the border rows
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        load_masks({$urandom, $urandom}, {$urandom, $urandom});
        for (int i = 0; i < 2 * FRAME_COLS + 40; i++)
            send_pixel(rand_pixel(), i == 0, 1'b0, NO_RESULT);
        settle();

        if (pending_mags.size() != 0) begin
            $display("%0t: %0d edge results never arrived", $time, pending_mags.size());
            errors += pending_mags.size();
        end
        $display("Sent %0d pixels, checked %0d edge results under %0d mask settings,",
                 items_sent, results_seen, mask_loads);
        $display("with border skips, mid-frame restarts, idle gaps and a long output hold.");
        if (errors == 0) begin
            $display("sobel_edge_magnitude_test OK");
        end else begin
            $display("sobel_edge_magnitude_test NOT OK");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("%0t: run did not complete in time", $time);
        $display("sobel_edge_magnitude_test NOT OK");
        $finish;
    end

endmodule
